[sv/aser_pkg.sv]
package aser_pkg;

	localparam int FRAC_BITS     = 30;
	localparam int X_W           = FRAC_BITS + 1;
	localparam int PREC_W        = 30;
	localparam int RES_W         = 40;
	localparam int MAG_W         = RES_W - 1;
	localparam int TERMS_OUT_W   = 8;
	localparam int MAX_TERMS_DEF = 128;

	localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(1074);
	localparam logic [MAG_W-1:0]  MAG_MAX    = {MAG_W{1'b1}};

	// handshake of the serial divider back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/aser_mul.sv]
module aser_mul #(
	parameter int AW = aser_pkg::FRAC_BITS,
	parameter int BW = aser_pkg::FRAC_BITS
) (
	input  logic             clk,
	input  logic [AW-1:0]    op_a,
	input  logic [BW-1:0]    op_b,
	output logic [AW+BW-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= (AW+BW)'(op_a) * (AW+BW)'(op_b);
	end

endmodule

[sv/aser_div.sv]
module aser_div #(
	parameter int DW = 39,
	parameter int VW = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DW-1:0]      dividend,
	input  logic [VW-1:0]      divisor,
	output aser_pkg::div_stat_t stat,
	output logic [DW-1:0]      quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic          fits;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(shifted - {1'b0, dsr_q}) : VW'(shifted);
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[sv/artanh_series_evaluator_unit.sv]
// artanh(x) by its Maclaurin series, signed Q1.30 in, signed Q10.30 out.
// Input channel: in_valid / in_stall with x_value. in_stall is high while an
// item is being worked on; one item at a time.
// Output channel: out_valid / out_stall with result, terms_used, hit_limit.
// The result sits in an output register, so the next item is taken while a
// finished result still waits; a result that finishes while the old one is
// still stalled waits in the sequencer until the register frees up.
// Config: cfg_wr_en / cfg_wr_data write the precision threshold (Q0.30);
// write only while the block is idle.
// DW = 30 + clog2(2*MAX_TERMS+2) is the dividend width of the serial divider
// (one quotient bit per cycle). Each term uses the one shared 30x30
// multiplier twice and then the divider.
// Reset (arst_n low, async) empties both channels and loads the precision
// threshold with 1074. A stalled output holds its item unchanged.
module artanh_series_evaluator_unit #(
	parameter int MAX_TERMS = aser_pkg::MAX_TERMS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [aser_pkg::PREC_W-1:0]           cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [aser_pkg::X_W-1:0]       x_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [aser_pkg::RES_W-1:0]     result,
	output logic [aser_pkg::TERMS_OUT_W-1:0]      terms_used,
	output logic                                  hit_limit
);

	localparam int F  = aser_pkg::FRAC_BITS;
	localparam int TW = $clog2(MAX_TERMS + 1);
	localparam int KW = TW + 1;
	localparam int DW = F + KW;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SQR  = 10'b0000000010,
		S_X2   = 10'b0000000100,
		S_TEST = 10'b0000001000,
		S_M1   = 10'b0000010000,
		S_M1W  = 10'b0000100000,
		S_M2   = 10'b0001000000,
		S_M2W  = 10'b0010000000,
		S_DIV  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t                          state_q;
	logic [aser_pkg::PREC_W-1:0]     precision_q;
	logic [F-1:0]                    a_q;
	logic [F-1:0]                    x2_q;
	logic [F-1:0]                    t_q;
	logic [aser_pkg::MAG_W-1:0]      sum_q;
	logic [TW-1:0]                   terms_q;
	logic                            neg_q;
	logic                            limit_q;
	logic                            out_valid_q;
	logic signed [aser_pkg::RES_W-1:0] result_q;
	logic [aser_pkg::TERMS_OUT_W-1:0] terms_used_q;
	logic                            hit_limit_q;

	logic [aser_pkg::X_W-1:0]        x_raw;
	logic [aser_pkg::X_W-1:0]        x_mag;
	logic [F-1:0]                    a_in;
	logic [aser_pkg::RES_W-1:0]      sum_add;
	logic [aser_pkg::MAG_W-1:0]      sum_next;
	logic [KW-1:0]                   odd_lo;
	logic [KW-1:0]                   odd_hi;
	logic [F-1:0]                    mul_a;
	logic [F-1:0]                    mul_b;
	logic [2*F-1:0]                  prod;
	logic                            div_start;
	aser_pkg::div_stat_t             div_stat;
	logic [DW-1:0]                   quotient;
	logic                            in_acc;
	logic                            out_free;
	logic [aser_pkg::RES_W-1:0]      mag_ext;

	// |x|, clamped below one
	assign x_raw = x_value;
	assign x_mag = x_raw[aser_pkg::X_W-1] ? (~x_raw + aser_pkg::X_W'(1)) : x_raw;
	assign a_in  = x_mag[F] ? {F{1'b1}} : x_mag[F-1:0];

	assign sum_add  = {1'b0, sum_q} + aser_pkg::RES_W'(t_q);
	assign sum_next = (sum_add > aser_pkg::RES_W'(aser_pkg::MAG_MAX)) ?
		aser_pkg::MAG_MAX : sum_add[aser_pkg::MAG_W-1:0];

	// 2k-1 and 2k+1, with k equal to the terms added so far
	assign odd_lo = {TW'(terms_q - TW'(1)), 1'b1};
	assign odd_hi = {terms_q, 1'b1};

	always_comb begin
		mul_a = t_q;
		mul_b = x2_q;
		case (state_q)
			S_SQR: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			S_M2: begin
				mul_b = F'(odd_lo);
			end
			default: begin
			end
		endcase
	end

	aser_mul #(.AW(F), .BW(F)) u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod)
	);

	assign div_start = state_q == S_M2W;

	aser_div #(.DW(DW), .VW(KW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod[DW-1:0]),
		.divisor  (odd_hi),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign in_stall = state_q != S_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mag_ext  = {1'b0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			precision_q <= aser_pkg::PREC_RESET;
			out_valid_q <= 1'b0;
			terms_q     <= '0;
			limit_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				precision_q <= cfg_wr_data;
			end
			// in S_DONE the sequencer itself decides the output valid
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						terms_q <= '0;
						limit_q <= 1'b0;
						state_q <= S_SQR;
					end
				end
				S_SQR: state_q <= S_X2;
				S_X2:  state_q <= S_TEST;
				S_TEST: begin
					if (t_q > precision_q) begin
						if (terms_q == TW'(MAX_TERMS)) begin
							limit_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							terms_q <= terms_q + TW'(1);
							state_q <= S_M1;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_M1:  state_q <= S_M1W;
				S_M1W: state_q <= S_M2;
				S_M2:  state_q <= S_M2W;
				S_M2W: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_TEST;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q   <= a_in;
			t_q   <= a_in;
			neg_q <= x_raw[aser_pkg::X_W-1];
			sum_q <= '0;
		end
		if (state_q == S_X2) begin
			x2_q <= prod[2*F-1:F];
		end
		if (state_q == S_TEST && t_q > precision_q && terms_q != TW'(MAX_TERMS)) begin
			sum_q <= sum_next;
		end
		if (state_q == S_M1W) begin
			t_q <= prod[2*F-1:F];
		end
		if (state_q == S_DIV && div_stat.done) begin
			t_q <= quotient[F-1:0];
		end
		if (state_q == S_DONE && out_free) begin
			result_q     <= neg_q ? -mag_ext : mag_ext;
			terms_used_q <= (32'(terms_q) > 32'd255) ? 8'hFF :
				aser_pkg::TERMS_OUT_W'(terms_q);
			hit_limit_q  <= limit_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign result     = result_q;
	assign terms_used = terms_used_q;
	assign hit_limit  = hit_limit_q;

`ifndef NO_ASSERTIONS
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_limit |->
		terms_used == ((MAX_TERMS > 255) ? 8'd255 : 8'(MAX_TERMS)))
		else $error("hit_limit without a full term count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted but block not busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_terms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(terms_q) <= MAX_TERMS)
		else $error("term counter past its bound");
`endif

endmodule

[verif/artanh_series_evaluator_unit_tb.sv]
`timescale 1ns / 100ps

module artanh_series_evaluator_unit_tb;

	localparam int     N_ITEM_BOUND    = 200;
	localparam int     LONGEST_STALL   = 300;
	localparam int     LONGEST_GAP     = 40;
	localparam int     ITEM_CYCLES     = 6000;
	localparam longint CYC_LIMIT       =
		3 * N_ITEM_BOUND * (ITEM_CYCLES + LONGEST_STALL + LONGEST_GAP);
	localparam int     DRAIN_CYCLES    = 60;
	localparam int     RAND_PHASES     = 5;
	localparam int     ITEMS_PER_PHASE = 28;
	localparam logic [aser_pkg::PREC_W-1:0] PREC_TOP = {aser_pkg::PREC_W{1'b1}};

	// directed items: at reset threshold, at zero threshold, at top threshold
	localparam logic [aser_pkg::X_W-1:0] X_AT_RESET [12] = '{
		31'h0000_0000, 31'h0000_0001, 31'h7FFF_FFFF, 31'd1074, 31'd1075, 31'h7FFF_FBCD,
		31'h2000_0000, 31'h6000_0000, 31'h3FFF_FFFF, 31'h4000_0000, 31'h4000_0001,
		31'h2AAA_AAAA};
	localparam logic [aser_pkg::X_W-1:0] X_AT_ZERO [7] = '{
		31'h0000_0000, 31'h0000_0001, 31'h7FFF_FFFF, 31'h0000_8000, 31'h1000_0000,
		31'h6FFF_CFC7, 31'h0000_0003};
	localparam logic [aser_pkg::X_W-1:0] X_AT_TOP [4] = '{
		31'h3FFF_FFFF, 31'h4000_0000, 31'h0000_0000, 31'h1234_5678};

	typedef struct {
		logic [aser_pkg::X_W-1:0]         x;
		logic [aser_pkg::RES_W-1:0]       res;
		logic [aser_pkg::TERMS_OUT_W-1:0] n_terms;
		logic                             limit;
	} artanh_expect_t;

	class artanh_scoreboard;
		logic [aser_pkg::PREC_W-1:0] precision;
		artanh_expect_t              awaiting[$];
		int                          n_bad;

		function new();
			precision = aser_pkg::PREC_RESET;
			n_bad     = 0;
		endfunction

		function void fault(string msg);
			n_bad++;
			if (n_bad <= 10)
				$display("%s", msg);
		endfunction

		// series on magnitudes, sign of x applied at the end
		function artanh_expect_t sum_series(logic [aser_pkg::X_W-1:0] raw);
			artanh_expect_t e;
			logic [63:0]    mag;
			logic [63:0]    x2;
			logic [63:0]    term;
			logic [63:0]    total;
			int unsigned    k;
			bit             neg;
			neg = raw[aser_pkg::X_W-1];
			mag = neg ? (64'd1 << aser_pkg::X_W) - 64'(raw) : 64'(raw);
			if (mag >= (64'd1 << aser_pkg::FRAC_BITS))
				mag = (64'd1 << aser_pkg::FRAC_BITS) - 1;
			x2      = (mag * mag) >> aser_pkg::FRAC_BITS;
			term    = mag;
			total   = '0;
			k       = 0;
			e.limit = 1'b0;
			while (term > 64'(precision)) begin
				if (k >= aser_pkg::MAX_TERMS_DEF) begin
					e.limit = 1'b1;
					break;
				end
				total += term;
				if (total > 64'(aser_pkg::MAG_MAX))
					total = 64'(aser_pkg::MAG_MAX);
				k++;
				term = (term * x2) >> aser_pkg::FRAC_BITS;
				term = (term * (2 * k - 1)) / (2 * k + 1);
			end
			e.x       = raw;
			e.res     = neg ? aser_pkg::RES_W'(64'd0 - total) : aser_pkg::RES_W'(total);
			e.n_terms = (k > 255) ? 8'd255 : aser_pkg::TERMS_OUT_W'(k);
			return e;
		endfunction

		function void note_x(logic [aser_pkg::X_W-1:0] raw);
			awaiting.push_back(sum_series(raw));
		endfunction

		function void check_result(logic [aser_pkg::RES_W-1:0] res,
				logic [aser_pkg::TERMS_OUT_W-1:0] nt, logic lim);
			artanh_expect_t e;
			if (awaiting.size() == 0) begin
				fault($sformatf("unexpected result: result=%h terms=%0d limit=%b",
					res, nt, lim));
			end else begin
				e = awaiting.pop_front();
				if (res !== e.res || nt !== e.n_terms || lim !== e.limit)
					fault($sformatf({"mismatch x=%h: result exp %h got %h, ",
						"terms exp %0d got %0d, limit exp %b got %b"},
						e.x, e.res, res, e.n_terms, nt, e.limit, lim));
			end
		endfunction
	endclass

	logic                                    clk;
	logic                                    arst_n;
	logic                                    cfg_wr_en;
	logic [aser_pkg::PREC_W-1:0]             cfg_wr_data;
	logic                                    in_valid;
	logic                                    in_stall;
	logic signed [aser_pkg::X_W-1:0]         x_value;
	logic                                    out_valid;
	logic                                    out_stall;
	logic signed [aser_pkg::RES_W-1:0]       result;
	logic [aser_pkg::TERMS_OUT_W-1:0]        terms_used;
	logic                                    hit_limit;

	artanh_scoreboard sb;
	longint           n_cycles = 0;
	int               burst_left;
	int               gap_max;
	int               rx_mode;
	int               rx_run;
	bit               rx_hold;

	artanh_series_evaluator_unit #(
		.MAX_TERMS(aser_pkg::MAX_TERMS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_value(x_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result),
		.terms_used(terms_used),
		.hit_limit(hit_limit)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYC_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_x(x_value);
			if (out_valid && !out_stall)
				sb.check_result(result, terms_used, hit_limit);
		end
	end

	// receiver: alternating free and stalled runs (mode 0 never stalls); mode 2 holds results long
	always @(posedge clk) begin
		if (rx_run > 0) begin
			rx_run--;
		end else begin
			rx_hold = (rx_mode != 0) && !rx_hold;
			if (rx_hold)
				rx_run = (rx_mode == 2) ? $urandom_range(LONGEST_STALL, 20)
					: $urandom_range(6, 1);
			else
				rx_run = $urandom_range(12, 0);
			out_stall <= rx_hold;
		end
	end

	function automatic logic [aser_pkg::X_W-1:0] rand_x();
		logic [aser_pkg::X_W-1:0] mag;
		case ($urandom_range(9, 0))
			0, 1, 2, 3, 4: return aser_pkg::X_W'($urandom);
			5, 6, 7: mag = aser_pkg::X_W'($urandom_range((1 << 29) - 1, 0));
			8: mag = aser_pkg::X_W'(sb.precision) + aser_pkg::X_W'($urandom_range(2, 0));
			default: mag = aser_pkg::X_W'((1 << 30) - $urandom_range(16, 0));
		endcase
		return $urandom_range(1, 0) ? aser_pkg::X_W'(0) - mag : mag;
	endfunction

	task automatic send_x(input logic [aser_pkg::X_W-1:0] v);
		in_valid <= 1'b1;
		x_value  <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (gap_max != 0) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				repeat ($urandom_range(gap_max, 1))
					@(posedge clk);
				burst_left = $urandom_range(8, 0);
			end
		end
	endtask

	task automatic wait_results_in();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaiting.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_precision(input logic [aser_pkg::PREC_W-1:0] v);
		wait_results_in();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.precision = v;
	endtask

	initial begin
		logic [aser_pkg::PREC_W-1:0] new_prec;
		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		x_value     = '0;
		out_stall   = 1'b0;
		rx_mode     = 1;
		rx_run      = 0;
		rx_hold     = 1'b0;
		gap_max     = 2;
		burst_left  = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold first, then the two extremes of the register
		foreach (X_AT_RESET[i])
			send_x(X_AT_RESET[i]);
		write_precision('0);
		foreach (X_AT_ZERO[i])
			send_x(X_AT_ZERO[i]);
		write_precision(PREC_TOP);
		foreach (X_AT_TOP[i])
			send_x(X_AT_TOP[i]);

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					new_prec = $urandom_range(4000, 0);
					gap_max  = 6;
					rx_mode  = 1;
				end
				1: begin
					new_prec = $urandom_range(PREC_TOP, 0);
					gap_max  = 30;
					rx_mode  = 2;
				end
				2: begin
					new_prec = aser_pkg::PREC_RESET;
					gap_max  = 0;
					rx_mode  = 0;
				end
				3: begin
					new_prec = $urandom_range(1 << 24, 1 << 16);
					gap_max  = LONGEST_GAP;
					rx_mode  = 2;
				end
				default: begin
					new_prec = '0;
					gap_max  = 3;
					rx_mode  = 1;
				end
			endcase
			write_precision(new_prec);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2)
					wait_results_in();
				send_x(rand_x());
			end
		end

		wait_results_in();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.n_bad == 0 && sb.awaiting.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
